@@ design/dywd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dywd_pkg
// Shared widths, constants, types and the month boundary table of the
// day-of-year to date and weekday converter.
// ----------------------------------------------------------------------------
package dywd_pkg;

   localparam int YEAR_W  = 14;
   localparam int DOY_W   = 9;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int WDAY_W  = 3;

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1900;
   // leap years in 1..1899
   localparam logic [15:0] LEAPS_BEFORE_EPOCH = 16'd460;

   // n / 100 as (n * 5243) >> 19, exact for n below 43690
   localparam int DIV100_MUL_W  = 13;
   localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
   localparam int DIV100_PROD_W = 27;
   localparam int DIV100_SHIFT  = 19;
   localparam int Q100_W        = DIV100_PROD_W - DIV100_SHIFT;

   // weekday sum, fits 15 bits for every year up to 16383
   localparam int WSUM_W = 15;
   localparam int SUM_W  = 16;

   // t / 7 as (t * 18725) >> 17, exact for t below 43690
   localparam logic [WSUM_W-1:0] DIV7_MUL = 15'd18725;
   localparam int DIV7_PROD_W = 30;
   localparam int DIV7_SHIFT  = 17;
   localparam int Q7_W        = DIV7_PROD_W - DIV7_SHIFT;

   localparam int MONTHS = 12;

   // last day number of each month in a common year
   localparam logic [DOY_W-1:0] MONTH_END [0:MONTHS-1] = '{
      9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

   typedef struct packed {
      logic [DOY_W-1:0]  dn;
      logic              leap;
      logic              invalid;
      logic [WSUM_W-1:0] wsum;
   } mid_type;

   function automatic logic [DOY_W-1:0] month_end(input logic [MONTH_W-1:0] idx,
                                                  input logic leap);
      logic [DOY_W-1:0] base;
      base = (idx > MONTH_W'(MONTHS - 1)) ? MONTH_END[MONTHS-1] : MONTH_END[idx];
      // february 29 shifts every month end from february on
      if (leap && (idx != '0)) begin
         base = base + DOY_W'(1);
      end
      return base;
   endfunction

endpackage

`default_nettype wire

@@ design/dywd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dywd request and response channels
// Valid/ready channels carrying the converter's request and response.
// ----------------------------------------------------------------------------
interface dywd_req_if import dywd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  year;
   logic [DOY_W-1:0]   day_of_year;

   modport source (output valid, year, day_of_year, input ready);
   modport sink   (input valid, year, day_of_year, output ready);
endinterface

interface dywd_rsp_if import dywd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MONTH_W-1:0] month;
   logic [DOM_W-1:0]   day_of_month;
   logic [WDAY_W-1:0]  weekday;
   logic               invalid;

   modport source (output valid, month, day_of_month, weekday, invalid, input ready);
   modport sink   (input valid, month, day_of_month, weekday, invalid, output ready);
endinterface

`default_nettype wire

@@ design/dywd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dywd_front
// Stages one and two: year divided by 100, leap rule, range check and the
// weekday sum of whole years before the given one plus its day number.
// ----------------------------------------------------------------------------
module dywd_front import dywd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [YEAR_W-1:0] in_year,
   input  wire logic [DOY_W-1:0]  in_dn,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output mid_type                out_data
);

   logic                     a_valid_ff, a_valid_in;
   logic [YEAR_W-1:0]        a_year_ff;
   logic [DOY_W-1:0]         a_dn_ff;
   logic [DIV100_PROD_W-1:0] a_prod_ff, a_prod_in;
   logic                     b_valid_ff, b_valid_in;
   mid_type                  b_mid_ff, b_mid_in;

   logic                     en_a, en_b;
   logic [YEAR_W-1:0]        in_nm1, a_nm1, r100;
   logic [Q100_W-1:0]        q100;
   logic                     cent, leap, after;
   logic [SUM_W-1:0]         t;
   logic [DOY_W-1:0]         ylen;

   assign en_b     = !b_valid_ff || out_ready;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;

   assign in_nm1    = in_year - YEAR_W'(1);
   assign a_prod_in = DIV100_PROD_W'(in_nm1) * DIV100_PROD_W'(DIV100_MUL);
   assign a_valid_in = en_a ? in_valid : a_valid_ff;

   // year - 1 split into hundreds and remainder
   assign a_nm1 = a_year_ff - YEAR_W'(1);
   assign q100  = a_prod_ff[DIV100_PROD_W-1:DIV100_SHIFT];
   assign r100  = a_nm1 - YEAR_W'(q100) * YEAR_W'(100);
   // year is a multiple of 100 when year - 1 ends in 99
   assign cent  = (r100 == YEAR_W'(99));
   assign leap  = (a_year_ff == '0)
               || ((a_year_ff[1:0] == 2'b00) && !cent)
               || (cent && (q100[1:0] == 2'b11));
   assign ylen  = leap ? DOY_W'(366) : DOY_W'(365);
   assign after = (a_year_ff > EPOCH_YEAR);

   // 365 = 1 mod 7, so each past year adds one plus its leap day
   assign t = SUM_W'(a_year_ff) - SUM_W'(EPOCH_YEAR) + SUM_W'(a_nm1[YEAR_W-1:2])
            - SUM_W'(q100) + SUM_W'(q100[Q100_W-1:2]) - LEAPS_BEFORE_EPOCH
            + SUM_W'(a_dn_ff);

   always_comb begin
      b_mid_in.dn      = a_dn_ff;
      b_mid_in.leap    = leap;
      b_mid_in.invalid = (a_dn_ff == '0) || (a_dn_ff > ylen);
      b_mid_in.wsum    = after ? t[WSUM_W-1:0] : WSUM_W'(a_dn_ff);
   end

   assign b_valid_in = en_b ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_year_ff <= in_year;
         a_dn_ff   <= in_dn;
         a_prod_ff <= a_prod_in;
      end
      if (en_b) begin
         b_mid_ff <= b_mid_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_mid_ff;

endmodule

`default_nettype wire

@@ design/dywd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dywd_back
// Stages three and four: month search, weekday sum modulo 7 and the
// response register.
// ----------------------------------------------------------------------------
module dywd_back import dywd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire mid_type       in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [MONTH_W-1:0] out_month,
   output logic [DOM_W-1:0]   out_dom,
   output logic [WDAY_W-1:0]  out_weekday,
   output logic               out_invalid
);

   logic                   c_valid_ff, c_valid_in;
   logic [DOY_W-1:0]       c_dn_ff;
   logic                   c_leap_ff;
   logic                   c_invalid_ff;
   logic [WSUM_W-1:0]      c_wsum_ff;
   logic [DIV7_PROD_W-1:0] c_prod_ff, c_prod_in;
   logic [MONTH_W-1:0]     c_idx_ff, c_idx_in;

   logic                   d_valid_ff, d_valid_in;
   logic [MONTH_W-1:0]     d_month_ff, d_month_in;
   logic [DOM_W-1:0]       d_dom_ff, d_dom_in;
   logic [WDAY_W-1:0]      d_wday_ff, d_wday_in;
   logic                   d_invalid_ff;

   logic                   en_c, en_d;
   logic [Q7_W-1:0]        q7;
   logic [WSUM_W-1:0]      r7;
   logic [DOY_W-1:0]       start, dom_full;

   assign en_d     = !d_valid_ff || out_ready;
   assign en_c     = !c_valid_ff || en_d;
   assign in_ready = en_c;

   assign c_prod_in  = DIV7_PROD_W'(in_data.wsum) * DIV7_PROD_W'(DIV7_MUL);
   assign c_valid_in = en_c ? in_valid : c_valid_ff;

   // month index = number of month ends already passed
   always_comb begin
      c_idx_in = '0;
      for (int i = 0; i < MONTHS - 1; i++) begin
         if (in_data.dn > month_end(MONTH_W'(i), in_data.leap)) begin
            c_idx_in = c_idx_in + MONTH_W'(1);
         end
      end
   end

   assign q7       = c_prod_ff[DIV7_PROD_W-1:DIV7_SHIFT];
   assign r7       = c_wsum_ff - WSUM_W'(q7) * WSUM_W'(7);
   assign start    = (c_idx_ff == '0) ? '0 : month_end(c_idx_ff - MONTH_W'(1), c_leap_ff);
   assign dom_full = c_dn_ff - start;

   always_comb begin
      if (c_invalid_ff) begin
         d_month_in = '0;
         d_dom_in   = '0;
         d_wday_in  = '0;
      end else begin
         d_month_in = c_idx_ff + MONTH_W'(1);
         d_dom_in   = dom_full[DOM_W-1:0];
         d_wday_in  = r7[WDAY_W-1:0];
      end
   end

   assign d_valid_in = en_d ? c_valid_ff : d_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_dn_ff      <= in_data.dn;
         c_leap_ff    <= in_data.leap;
         c_invalid_ff <= in_data.invalid;
         c_wsum_ff    <= in_data.wsum;
         c_prod_ff    <= c_prod_in;
         c_idx_ff     <= c_idx_in;
      end
      if (en_d) begin
         d_month_ff   <= d_month_in;
         d_dom_ff     <= d_dom_in;
         d_wday_ff    <= d_wday_in;
         d_invalid_ff <= c_invalid_ff;
      end
   end

   assign out_valid   = d_valid_ff;
   assign out_month   = d_month_ff;
   assign out_dom     = d_dom_ff;
   assign out_weekday = d_wday_ff;
   assign out_invalid = d_invalid_ff;

endmodule

`default_nettype wire

@@ design/day_of_year_to_date_weekday_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// day_of_year_to_date_weekday_top
// Converts a Gregorian year and day number into month, day of month and
// weekday (0 = Sunday), flagging day numbers outside the year.
//
//   channel  dir  handshake      payload
//   req_ch   in   valid / ready  year[13:0], day_of_year[8:0]
//   rsp_ch   out  valid / ready  month[3:0], day_of_month[4:0], weekday[2:0],
//                                invalid
//
// One request per cycle unless a stalled response holds the stages; each request passes every stage register in turn.
// The four stages follow the two constant multiplies (by 1/100, by 1/7),
// each with a register behind it.
// Synchronous reset clears the stage valid bits only.
// Each stage holds while the next is full and stalled; empty stages still
// fill, so up to three more requests are taken while a response waits.
// ----------------------------------------------------------------------------
module day_of_year_to_date_weekday_top import dywd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   dywd_req_if.sink    req_ch,
   dywd_rsp_if.source  rsp_ch
);

   logic    mid_valid, mid_ready;
   mid_type mid_data;

   dywd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_year   (req_ch.year),
      .in_dn     (req_ch.day_of_year),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   dywd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (mid_valid),
      .in_ready    (mid_ready),
      .in_data     (mid_data),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_month   (rsp_ch.month),
      .out_dom     (rsp_ch.day_of_month),
      .out_weekday (rsp_ch.weekday),
      .out_invalid (rsp_ch.invalid)
   );

endmodule

`default_nettype wire

@@ design/dywd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dywd_port_checker
// Port-level checks on the converter's response channel.
// ----------------------------------------------------------------------------
module dywd_port_checker import dywd_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [MONTH_W-1:0] month,
   input wire logic [DOM_W-1:0]   day_of_month,
   input wire logic [WDAY_W-1:0]  weekday,
   input wire logic               invalid
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(month)
         && $stable(day_of_month) && $stable(weekday) && $stable(invalid))
      else $error("stalled response changed");

   // a flagged day number carries no date
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && invalid |-> month == '0 && day_of_month == '0 && weekday == '0)
      else $error("invalid response with nonzero date");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !invalid |-> month >= MONTH_W'(1) && month <= MONTH_W'(12)
         && day_of_month != '0 && weekday <= WDAY_W'(6))
      else $error("date field out of range");

endmodule

bind day_of_year_to_date_weekday_top dywd_port_checker u_dywd_port_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .month        (rsp_ch.month),
   .day_of_month (rsp_ch.day_of_month),
   .weekday      (rsp_ch.weekday),
   .invalid      (rsp_ch.invalid)
);

`default_nettype wire

@@ tb/dywd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dywd_checker
// Watches the request and response channels of the date converter, works out
// month, day of month and weekday for every accepted request, and compares
// each accepted response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dywd_checker import dywd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dywd_req_if       req_ch,
   dywd_rsp_if       rsp_ch,
   output int        fail_count,
   output int        pending
);

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [MONTH_W-1:0] month;
      logic [DOM_W-1:0]   day_of_month;
      logic [WDAY_W-1:0]  weekday;
      logic               invalid;
   } date_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [DOY_W-1:0]  day_of_year;
      date_type          date;
   } conversion_type;

   conversion_type expected_dates[$];

   // leap years in 1..n
   function automatic int unsigned leaps_through(input int unsigned n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic date_type convert_date(input logic [YEAR_W-1:0] year,
                                             input logic [DOY_W-1:0] day_of_year);
      date_type     result;
      int unsigned  y;
      int unsigned  rest;
      int unsigned  span;
      int unsigned  mon;
      int unsigned  elapsed;
      bit           leap;
      y      = year;
      leap   = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      result = '0;
      if (day_of_year == '0 || day_of_year > (leap ? 366 : 365)) begin
         result.invalid = 1'b1;
         return result;
      end
      // years before the epoch contribute nothing to the day count
      elapsed = 0;
      if (y > EPOCH_YEAR) begin
         elapsed = 365 * (y - EPOCH_YEAR) + leaps_through(y - 1)
                   - leaps_through(EPOCH_YEAR - 1);
      end
      rest = day_of_year;
      mon  = 1;
      while (mon < 12) begin
         if (mon == 2) span = leap ? 29 : 28;
         else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) span = 30;
         else span = 31;
         if (rest <= span) break;
         rest = rest - span;
         mon++;
      end
      result.month        = MONTH_W'(mon);
      result.day_of_month = DOM_W'(rest);
      result.weekday      = WDAY_W'((elapsed + day_of_year) % 7);
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch_channels
      conversion_type head;
      string          tag;
      if (reset) begin
         expected_dates.delete();
         fail_count = 0;
         pending    = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            head.year        = req_ch.year;
            head.day_of_year = req_ch.day_of_year;
            head.date        = convert_date(req_ch.year, req_ch.day_of_year);
            expected_dates.push_back(head);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_dates.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               head = expected_dates.pop_front();
               tag  = $sformatf("year %0d day %0d", head.year, head.day_of_year);
               if (rsp_ch.month !== head.date.month) begin
                  report_mismatch($sformatf("%s month %0d, want %0d", tag,
                                            rsp_ch.month, head.date.month));
               end
               if (rsp_ch.day_of_month !== head.date.day_of_month) begin
                  report_mismatch($sformatf("%s day_of_month %0d, want %0d", tag,
                                            rsp_ch.day_of_month, head.date.day_of_month));
               end
               if (rsp_ch.weekday !== head.date.weekday) begin
                  report_mismatch($sformatf("%s weekday %0d, want %0d", tag,
                                            rsp_ch.weekday, head.date.weekday));
               end
               if (rsp_ch.invalid !== head.date.invalid) begin
                  report_mismatch($sformatf("%s invalid %0b, want %0b", tag,
                                            rsp_ch.invalid, head.date.invalid));
               end
            end
         end
         pending = expected_dates.size();
      end
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives year / day-number requests into the date converter: a directed set
// around leap rules, year ends and out-of-range day numbers, then random
// requests, with random stalls on both channels. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import dywd_pkg::*;

   localparam int RANDOM_REQUESTS = 1350;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 16;

   logic clock;
   logic reset;
   bit   quiet;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;

   dywd_req_if req_ch();
   dywd_rsp_if rsp_ch();

   day_of_year_to_date_weekday_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dywd_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input int unsigned year, input int unsigned day_of_year);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid       <= 1'b0;
         req_ch.year        <= YEAR_W'($urandom);
         req_ch.day_of_year <= DOY_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.year        <= YEAR_W'(year);
      req_ch.day_of_year <= DOY_W'(day_of_year);
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   // response side: a random stall before each response
   initial begin
      int unsigned gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns watchdog: no handshake for %0d cycles, %0d outstanding",
                  $time, WATCHDOG_LIMIT, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned y;
      int unsigned d;
      int unsigned year_len;
      int unsigned sel;
      reset              = 1'b1;
      quiet              = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.year        = '0;
      req_ch.day_of_year = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // epoch, year ends, leap february, century rules
      send_request(1900, 1);
      send_request(1900, 365);
      send_request(1900, 366);
      send_request(1900, 0);
      send_request(2000, 60);
      send_request(2000, 366);
      send_request(2100, 60);
      send_request(2100, 366);
      send_request(2024, 367);
      send_request(2023, 59);
      send_request(2023, 60);
      send_request(2024, 335);
      send_request(1904, 366);
      send_request(9999, 365);
      // years before the epoch, year zero counts as leap
      send_request(0, 366);
      send_request(0, 1);
      send_request(1899, 365);
      send_request(1899, 366);
      // top of the year field and top of the day field
      send_request(16383, 511);
      send_request(16383, 1);
      send_request(16000, 366);
      send_request(8192, 256);
      send_request(2024, 511);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if ($urandom_range(0, 39) == 0) quiet = !quiet;
         sel = $urandom_range(0, 19);
         if (sel < 13) y = $urandom_range(1900, 9999);
         else if (sel < 15) y = $urandom_range(0, 1899);
         else if (sel < 17) y = $urandom_range(10000, 16383);
         else y = 100 * $urandom_range(0, 163);
         year_len = (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 366 : 365;
         sel = $urandom_range(0, 19);
         if (sel < 14) d = $urandom_range(1, year_len);
         else if (sel < 17) d = $urandom_range(year_len - 1, year_len + 1);
         else if (sel == 17) d = 0;
         else d = $urandom_range(year_len + 1, 511);
         send_request(y, d);
      end
      req_ch.valid <= 1'b0;

      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
